// ===== rtl/grbf_pkg.sv =====
// Shared types, constants and the exponential table for the Gaussian RBF evaluator.
// No dependencies.
package grbf_pkg;

  localparam int MAX_CENTERS = 16;
  localparam int DIMENSIONS  = 6;
  localparam int IDX_W       = $clog2(MAX_CENTERS);
  localparam int CNT_W       = $clog2(MAX_CENTERS + 1);
  localparam int EXP_ENTRIES = 256;
  localparam int ACC_W       = 40;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         center_index;
    logic signed [15:0] coord_0;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_3;
    logic signed [15:0] coord_4;
    logic signed [15:0] coord_5;
    logic signed [31:0] weight_real;
    logic signed [31:0] weight_imag;
    logic [15:0]        kernel_width;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sum_real;
    logic signed [31:0] sum_imag;
  } out_t;

  typedef struct packed {
    logic signed [DIMENSIONS-1:0][15:0] pos;
    logic signed [31:0]                 wr;
    logic signed [31:0]                 wi;
    logic [15:0]                        width;
  } center_t;

  typedef struct packed {
    logic             load;
    logic             start;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } dp_status_t;

  typedef logic [16:0] exp_tab_t [EXP_ENTRIES];

  // exp(-k/16) in Q1.16, built by repeated multiplication with exp(-1/16) in Q0.32
  function automatic exp_tab_t build_exp();
    exp_tab_t t;
    logic [63:0] v;
    logic [63:0] p;
    v = 64'd1 << 32;
    for (int k = 0; k < EXP_ENTRIES; k++) begin
      p = v + 64'h8000;
      t[k] = p[32:16];
      p = v * 64'd4034748382 + 64'h8000_0000;
      v = {32'd0, p[63:32]};
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp();

endpackage

// ===== rtl/grbf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module grbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/grbf_ctrl.sv =====
// Controller: input handshake, centre walk and result hand-off.
// Depends on grbf_pkg.
module grbf_ctrl import grbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    RUN   = 4'b0010,
    DRAIN = 4'b0100,
    FIN   = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [4:0]       centers_in_use;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] n;
  logic             accept;

  assign n = (centers_in_use > 5'(MAX_CENTERS)) ? CNT_W'(MAX_CENTERS)
                                                : CNT_W'(centers_in_use);
  assign in_stall = (state != IDLE);
  assign accept   = in_valid && (state == IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.rd_addr  = cnt;
    case (state)
      IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            cnt_next  = '0;
            state_next = (n == '0) ? FIN : RUN;
          end
        end
      end
      RUN: begin
        cmd.rd_en = 1'b1;
        if (CNT_W'(cnt) == n - CNT_W'(1)) begin
          state_next = DRAIN;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      DRAIN: begin
        if (!status.busy) begin
          state_next = FIN;
        end
      end
      FIN: begin
        // wait for the previous result beat to leave
        if (!status.out_full || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      cnt            <= '0;
      centers_in_use <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_we) begin
        centers_in_use <= cfg_data;
      end
    end
  end

endmodule

// ===== rtl/grbf_dp.sv =====
// Datapath: centre table, distance, exponential, weighting and accumulation pipeline.
// Depends on grbf_pkg and grbf_ram.
module grbf_dp import grbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  in_t        in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  center_t wdata, q;
  logic signed [DIMENSIONS-1:0][15:0] pt;
  logic [7:0] v;

  assign wdata.pos   = {in_data.coord_5, in_data.coord_4, in_data.coord_3,
                        in_data.coord_2, in_data.coord_1, in_data.coord_0};
  assign wdata.wr    = in_data.weight_real;
  assign wdata.wi    = in_data.weight_imag;
  assign wdata.width = in_data.kernel_width;

  grbf_ram #(.WIDTH($bits(center_t)), .DEPTH(MAX_CENTERS)) u_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (in_data.center_index[IDX_W-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (q)
  );

  // stage 1: squared differences and width squared
  logic [DIMENSIONS-1:0][31:0] sq1;
  logic [31:0]        e2_1, e2_2;
  logic signed [31:0] wr1, wi1, wr2, wi2, wr3, wi3, wr4, wi4, wr5, wi5, wr6, wi6;
  logic [34:0]        dist2;
  logic [42:0]        ph3;
  logic [55:0]        pl3;
  logic [43:0]        arg;
  logic               big4, big5;
  logic [16:0]        y0_4, dy4, y1, y0_5;
  logic [19:0]        frac4;
  logic [36:0]        prod5, rnd;
  logic [16:0]        g6;
  logic signed [48:0] pr7, pi7, tr, ti;
  logic signed [ACC_W-1:0] acc_r, acc_i;
  logic [DIMENSIONS-1:0][31:0] sq_c;
  logic [34:0]        dsum;
  logic [7:0]         idx;

  always_comb begin
    for (int d = 0; d < DIMENSIONS; d++) begin
      logic signed [16:0] df;
      logic [15:0] a;
      df = {pt[d][15], pt[d]} - {q.pos[d][15], q.pos[d]};
      a  = df[16] ? 16'(-df) : df[15:0];
      sq_c[d] = a * a;
    end
    dsum = '0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      dsum = dsum + 35'(sq1[d]);
    end
  end

  assign arg = 44'(ph3) + 44'(pl3[55:24]);
  assign idx = arg[27:20];
  assign y1  = (idx == 8'(EXP_ENTRIES - 1)) ? 17'd0 : EXP_TAB[idx + 8'd1];
  assign rnd = prod5 + 37'h80000;
  assign tr  = (pr7 + 49'sh8000) >>> 16;
  assign ti  = (pi7 + 49'sh8000) >>> 16;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pt <= {in_data.coord_5, in_data.coord_4, in_data.coord_3,
             in_data.coord_2, in_data.coord_1, in_data.coord_0};
    end
    sq1   <= sq_c;
    e2_1  <= q.width * q.width;
    wr1   <= q.wr;  wi1 <= q.wi;
    dist2 <= dsum;
    e2_2  <= e2_1;  wr2 <= wr1;  wi2 <= wi1;
    ph3   <= e2_2 * dist2[34:24];
    pl3   <= e2_2 * dist2[23:0];
    wr3   <= wr2;   wi3 <= wi2;
    big4  <= (arg[43:28] != '0);
    y0_4  <= EXP_TAB[idx];
    dy4   <= EXP_TAB[idx] - y1;
    frac4 <= arg[19:0];
    wr4   <= wr3;   wi4 <= wi3;
    prod5 <= dy4 * frac4;
    y0_5  <= y0_4;
    big5  <= big4;
    wr5   <= wr4;   wi5 <= wi4;
    g6    <= big5 ? 17'd0 : y0_5 - rnd[36:20];
    wr6   <= wr5;   wi6 <= wi5;
    pr7   <= wr6 * $signed({1'b0, g6});
    pi7   <= wi6 * $signed({1'b0, g6});
  end

  // accumulate and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      v <= {v[6:0], cmd.rd_en};
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] sat(logic signed [ACC_W-1:0] s);
    if (s > ACC_W'(64'sd2147483647)) begin
      return 32'h7fff_ffff;
    end else if (s < -ACC_W'(64'sd2147483648)) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
      acc_i <= '0;
    end else if (v[7]) begin
      acc_r <= acc_r + ACC_W'(tr);
      acc_i <= acc_i + ACC_W'(ti);
    end
    if (cmd.out_load) begin
      out_data.sum_real <= sat(acc_r);
      out_data.sum_imag <= sat(acc_i);
    end
  end

  assign status.busy     = |v;
  assign status.out_full = out_valid;

endmodule

// ===== rtl/gaussian_rbf_field_evaluator.sv =====
// Gaussian RBF field evaluator, top level.
// Load beat: writes one centre into the table. Evaluate beat: one centre per cycle for the n
// centres in use through the distance/exp/weight pipeline, then a drain; zero sum with none.
// One item at a time; a waiting result holds up only the next hand-off, not loads or starts.
// Synchronous active-high reset clears control and the centre count; the table is not cleared.
module gaussian_rbf_field_evaluator import grbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  grbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_data.cmd),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  grbf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
